/* rtl/vsrt_pkg.sv */
// ----------------------------------------------------------------------------
// vsrt_pkg
// Shared widths, register indexes and saturation helper for the vertex
// scale / rotate / translate pipeline.
// ----------------------------------------------------------------------------
package vsrt_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register widths
  localparam int SCALE_W   = 16;
  localparam int TRIG_W    = 16;
  localparam int ROT_REG_W = 2 * TRIG_W;
  localparam int OFFSET_W  = 32;

  // Datapath widths
  localparam int INNER_W = 46;                    // saturated inner coordinate
  localparam int SPLIT_W = INNER_W / 2;           // low partial-product slice
  localparam int WIDE_W  = INNER_W + TRIG_W + 1;  // sum of two rotation products
  localparam int OUT_W   = 40;

  // Register reset values
  localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(256);
  localparam logic [ROT_REG_W-1:0] ROT_RESET   = ROT_REG_W'(16384);

  localparam logic signed [INNER_W-1:0] INNER_MAX = {1'b0, {(INNER_W-1){1'b1}}};
  localparam logic signed [INNER_W-1:0] INNER_MIN = {1'b1, {(INNER_W-1){1'b0}}};

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_ROT_X    = 3'd1,
    REG_ROT_Y    = 3'd2,
    REG_ROT_Z    = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } cfg_reg_e;

  // Clamp a wide signed value to the inner coordinate range
  function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-INNER_W:0] top;
    logic signed [INNER_W-1:0] res;
    top = v[WIDE_W-1:INNER_W-1];
    if (&top || ~|top) begin
      res = v[INNER_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = INNER_MIN;
    end else begin
      res = INNER_MAX;
    end
    return res;
  endfunction

endpackage

/* rtl/vsrt_rot.sv */
// ----------------------------------------------------------------------------
// vsrt_rot
// Three-stage plane rotation of a coordinate pair (p, q) by a sine/cosine
// pair: p' = round(p*c - q*s), q' = round(p*s + q*c). The third coordinate
// r rides along unchanged.
// ----------------------------------------------------------------------------
module vsrt_rot #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [vsrt_pkg::INNER_W-1:0]    p_i,
  input  logic signed [vsrt_pkg::INNER_W-1:0]    q_i,
  input  logic signed [vsrt_pkg::INNER_W-1:0]    r_i,
  input  logic        [vsrt_pkg::ROT_REG_W-1:0]  sin_cos_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic signed [vsrt_pkg::INNER_W-1:0]    p_o,
  output logic signed [vsrt_pkg::INNER_W-1:0]    q_o,
  output logic signed [vsrt_pkg::INNER_W-1:0]    r_o
);

  localparam int InnerW  = vsrt_pkg::INNER_W;
  localparam int SplitW  = vsrt_pkg::SPLIT_W;
  localparam int TrigW   = vsrt_pkg::TRIG_W;
  localparam int WideW   = vsrt_pkg::WIDE_W;
  localparam int LoW     = SplitW + 1;
  localparam int HiW     = InnerW - SplitW;
  localparam int LoProdW = LoW + TrigW;
  localparam int HiProdW = HiW + TrigW;
  localparam int ProdW   = InnerW + TrigW;
  localparam logic signed [WideW-1:0] RndHalf = WideW'(1) << (TRIG_FRAC_BITS - 1);

  // Stage valids and per-stage advance
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: split partial products. Order: p*c, q*s, p*s, q*c
  logic signed [TrigW-1:0]   sin_v, cos_v;
  logic signed [LoW-1:0]     p_lo, q_lo;
  logic signed [HiW-1:0]     p_hi, q_hi;
  logic signed [LoProdW-1:0] lo_d [4];
  logic signed [HiProdW-1:0] hi_d [4];
  logic signed [LoProdW-1:0] lo_q [4];
  logic signed [HiProdW-1:0] hi_q [4];
  logic signed [InnerW-1:0]  r1_q;

  assign sin_v = sin_cos_i[2*TrigW-1:TrigW];
  assign cos_v = sin_cos_i[TrigW-1:0];
  assign p_lo  = {1'b0, p_i[SplitW-1:0]};
  assign q_lo  = {1'b0, q_i[SplitW-1:0]};
  assign p_hi  = p_i[InnerW-1:SplitW];
  assign q_hi  = q_i[InnerW-1:SplitW];

  always_comb begin
    lo_d[0] = p_lo * cos_v;
    hi_d[0] = p_hi * cos_v;
    lo_d[1] = q_lo * sin_v;
    hi_d[1] = q_hi * sin_v;
    lo_d[2] = p_lo * sin_v;
    hi_d[2] = p_hi * sin_v;
    lo_d[3] = q_lo * cos_v;
    hi_d[3] = q_hi * cos_v;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int k = 0; k < 4; k++) begin
        lo_q[k] <= lo_d[k];
        hi_q[k] <= hi_d[k];
      end
      r1_q <= r_i;
    end
  end

  // Stage 2: recombine each product
  logic signed [ProdW-1:0]  prod_d [4];
  logic signed [ProdW-1:0]  prod_q [4];
  logic signed [InnerW-1:0] r2_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_d[k] = (ProdW'(hi_q[k]) <<< SplitW) + ProdW'(lo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= prod_d[k];
      end
      r2_q <= r1_q;
    end
  end

  // Stage 3: sum, round to nearest, saturate
  logic signed [WideW-1:0]  sum_p, sum_q;
  logic signed [WideW-1:0]  sh_p, sh_q;
  logic signed [InnerW-1:0] p3_q, q3_q, r3_q;

  assign sum_p = WideW'(prod_q[0]) - WideW'(prod_q[1]) + RndHalf;
  assign sum_q = WideW'(prod_q[2]) + WideW'(prod_q[3]) + RndHalf;
  assign sh_p  = sum_p >>> TRIG_FRAC_BITS;
  assign sh_q  = sum_q >>> TRIG_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      p3_q <= vsrt_pkg::sat_inner(sh_p);
      q3_q <= vsrt_pkg::sat_inner(sh_q);
      r3_q <= r2_q;
    end
  end

  assign p_o = p3_q;
  assign q_o = q3_q;
  assign r_o = r3_q;

endmodule

/* rtl/vertex_scale_rotate_translate_core.sv */
// Stages: scale, rotation about X, Y and Z, then offset and output register.
// Throughput: one vertex per cycle while the output does not stall; each stage
//   advances on its own, so bubbles close up while the output stalls.
// Reset: clears all stage valids and loads the register defaults
//   (unit scale, zero angles, zero offsets).
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate_core
// Scales a signed vertex, rotates it about X, then Y, then Z, adds an offset
// and saturates the result to 40-bit Q.8.
// ----------------------------------------------------------------------------
module vertex_scale_rotate_translate_core #(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [vsrt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vsrt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]        in_x_i,
  input  logic signed [COORD_WIDTH-1:0]        in_y_i,
  input  logic signed [COORD_WIDTH-1:0]        in_z_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vsrt_pkg::OUT_W-1:0]    out_x_o,
  output logic signed [vsrt_pkg::OUT_W-1:0]    out_y_o,
  output logic signed [vsrt_pkg::OUT_W-1:0]    out_z_o
);

  localparam int InnerW   = vsrt_pkg::INNER_W;
  localparam int WideW    = vsrt_pkg::WIDE_W;
  localparam int OutW     = vsrt_pkg::OUT_W;
  localparam int OffsetW  = vsrt_pkg::OFFSET_W;
  localparam int ScaledW  = COORD_WIDTH + vsrt_pkg::SCALE_W + 1;
  localparam int OffSumW  = InnerW + 1;

  // Configuration registers
  logic        [vsrt_pkg::SCALE_W-1:0]   scale_q;
  logic        [vsrt_pkg::ROT_REG_W-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic signed [OffsetW-1:0]             off_x_q, off_y_q, off_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= vsrt_pkg::SCALE_RESET;
      rot_x_q <= vsrt_pkg::ROT_RESET;
      rot_y_q <= vsrt_pkg::ROT_RESET;
      rot_z_q <= vsrt_pkg::ROT_RESET;
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (vsrt_pkg::cfg_reg_e'(cfg_idx_i))
        vsrt_pkg::REG_SCALE:    scale_q <= cfg_data_i[vsrt_pkg::SCALE_W-1:0];
        vsrt_pkg::REG_ROT_X:    rot_x_q <= cfg_data_i[vsrt_pkg::ROT_REG_W-1:0];
        vsrt_pkg::REG_ROT_Y:    rot_y_q <= cfg_data_i[vsrt_pkg::ROT_REG_W-1:0];
        vsrt_pkg::REG_ROT_Z:    rot_z_q <= cfg_data_i[vsrt_pkg::ROT_REG_W-1:0];
        vsrt_pkg::REG_OFFSET_X: off_x_q <= cfg_data_i[OffsetW-1:0];
        vsrt_pkg::REG_OFFSET_Y: off_y_q <= cfg_data_i[OffsetW-1:0];
        vsrt_pkg::REG_OFFSET_Z: off_z_q <= cfg_data_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain between stages
  logic rx_valid, rx_ready, ry_valid, ry_ready, rz_valid, rz_ready;
  logic s0_v_q, s0_en;
  logic out_v_q, out_en;

  assign out_en      = !out_v_q || out_ready_i;
  assign s0_en       = !s0_v_q || rx_ready;
  assign in_ready_o  = s0_en;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_en)  s0_v_q  <= in_valid_i;
      if (out_en) out_v_q <= rz_valid;
    end
  end

  // Scale stage: coordinate times unsigned Q8.8, clamp to inner range
  logic signed [vsrt_pkg::SCALE_W:0] scale_s;
  logic signed [ScaledW-1:0]         sx, sy, sz;
  logic signed [InnerW-1:0]          s0_x_q, s0_y_q, s0_z_q;

  assign scale_s = signed'({1'b0, scale_q});
  assign sx      = in_x_i * scale_s;
  assign sy      = in_y_i * scale_s;
  assign sz      = in_z_i * scale_s;

  always_ff @(posedge clk_i) begin
    if (s0_en) begin
      s0_x_q <= vsrt_pkg::sat_inner(WideW'(sx));
      s0_y_q <= vsrt_pkg::sat_inner(WideW'(sy));
      s0_z_q <= vsrt_pkg::sat_inner(WideW'(sz));
    end
  end

  // Rotation about X: pair (y, z), x rides along
  logic signed [InnerW-1:0] rx_p, rx_q, rx_r;

  vsrt_rot #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s0_v_q),
    .ready_o   (rx_ready),
    .p_i       (s0_y_q),
    .q_i       (s0_z_q),
    .r_i       (s0_x_q),
    .sin_cos_i (rot_x_q),
    .valid_o   (rx_valid),
    .ready_i   (ry_ready),
    .p_o       (rx_p),
    .q_o       (rx_q),
    .r_o       (rx_r)
  );

  // Rotation about Y: pair (z, x), y rides along
  logic signed [InnerW-1:0] ry_p, ry_q, ry_r;

  vsrt_rot #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_valid),
    .ready_o   (ry_ready),
    .p_i       (rx_q),
    .q_i       (rx_r),
    .r_i       (rx_p),
    .sin_cos_i (rot_y_q),
    .valid_o   (ry_valid),
    .ready_i   (rz_ready),
    .p_o       (ry_p),
    .q_o       (ry_q),
    .r_o       (ry_r)
  );

  // Rotation about Z: pair (x, y), z rides along
  logic signed [InnerW-1:0] rz_p, rz_q, rz_r;

  vsrt_rot #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (ry_valid),
    .ready_o   (rz_ready),
    .p_i       (ry_q),
    .q_i       (ry_r),
    .r_i       (ry_p),
    .sin_cos_i (rot_z_q),
    .valid_o   (rz_valid),
    .ready_i   (out_en),
    .p_o       (rz_p),
    .q_o       (rz_q),
    .r_o       (rz_r)
  );

  // Offset and clamp to the output range
  logic signed [OffSumW-1:0] ox, oy, oz;
  logic signed [OutW-1:0]    out_x_d, out_y_d, out_z_d;
  logic signed [OutW-1:0]    out_x_q, out_y_q, out_z_q;

  localparam logic signed [OutW-1:0] OutMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] OutMin = {1'b1, {(OutW-1){1'b0}}};

  assign ox = OffSumW'(rz_p) + OffSumW'(off_x_q);
  assign oy = OffSumW'(rz_q) + OffSumW'(off_y_q);
  assign oz = OffSumW'(rz_r) + OffSumW'(off_z_q);

  always_comb begin
    out_x_d = ox[OutW-1:0];
    if (!(&ox[OffSumW-1:OutW-1] || ~|ox[OffSumW-1:OutW-1])) begin
      out_x_d = ox[OffSumW-1] ? OutMin : OutMax;
    end
    out_y_d = oy[OutW-1:0];
    if (!(&oy[OffSumW-1:OutW-1] || ~|oy[OffSumW-1:OutW-1])) begin
      out_y_d = oy[OffSumW-1] ? OutMin : OutMax;
    end
    out_z_d = oz[OutW-1:0];
    if (!(&oz[OffSumW-1:OutW-1] || ~|oz[OffSumW-1:OutW-1])) begin
      out_z_d = oz[OffSumW-1] ? OutMin : OutMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      out_z_q <= out_z_d;
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

/* bench/tb_vertex_scale_rotate_translate_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vertex_scale_rotate_translate_core
// Self-checking bench for the vertex transform pipeline. A short directed
// table of register writes and vertices runs first, then random vertices
// under a series of register settings. Every output beat is scored against
// a behavioural transform kept in the bench or a hand-typed expectation.
// ---------------------------------------------------------------------------
module tb_vertex_scale_rotate_translate_core;
  import vsrt_pkg::*;

  localparam int COORD_W         = 16;
  localparam int FRAC_BITS       = 14;
  localparam int PHASES          = 9;
  localparam int PHASE_VERTICES  = 190;
  localparam int SETTLE_CYCLES   = 16;      // comfortably past the pipeline latency
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } vertex_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    coord_t                x;
    coord_t                y;
    coord_t                z;
    bit                    typed;
    vertex_t               want;
  } plan_row_t;

  // DUT connections
  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  coord_t                  in_x_i     = '0;
  coord_t                  in_y_i     = '0;
  coord_t                  in_z_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] out_x_o;
  logic signed [OUT_W-1:0] out_y_o;
  logic signed [OUT_W-1:0] out_z_o;

  // Register shadow: rotations and offsets indexed X, Y, Z
  logic [SCALE_W-1:0]   scale_q;
  logic [ROT_REG_W-1:0] rot_q [3];
  logic [OFFSET_W-1:0]  offset_q [3];

  vertex_t   pending_vertices [$];
  plan_row_t directed_plan [$];

  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_off_req = 1'b0;

  int unsigned vertices_sent   = 0;
  int unsigned vertices_scored = 0;
  int unsigned settings_loaded = 0;
  int unsigned fail_count      = 0;

  vertex_scale_rotate_translate_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioural transform
  // ---------------------------------------------------------------------------
  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Q1.14 product sum back to Q.8, round half up, clamp to the inner width
  function automatic longint trig_round(input longint acc);
    return clamp_signed((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, INNER_W);
  endfunction

  function automatic vertex_t transform_vertex(input coord_t vx, input coord_t vy,
                                               input coord_t vz);
    longint  p [3];
    longint  s, c, a, b;
    int      u, w;
    vertex_t res;
    p[0] = clamp_signed(longint'(vx) * longint'(scale_q), INNER_W);
    p[1] = clamp_signed(longint'(vy) * longint'(scale_q), INNER_W);
    p[2] = clamp_signed(longint'(vz) * longint'(scale_q), INNER_W);
    // X turns (y,z), Y turns (z,x), Z turns (x,y): all share one form
    for (int k = 0; k < 3; k++) begin
      u = (k + 1) % 3;
      w = (k + 2) % 3;
      s = longint'($signed(rot_q[k][ROT_REG_W-1:TRIG_W]));
      c = longint'($signed(rot_q[k][TRIG_W-1:0]));
      a = trig_round(p[u] * c - p[w] * s);
      b = trig_round(p[u] * s + p[w] * c);
      p[u] = a;
      p[w] = b;
    end
    res.x = OUT_W'(clamp_signed(p[0] + longint'($signed(offset_q[0])), OUT_W));
    res.y = OUT_W'(clamp_signed(p[1] + longint'($signed(offset_q[1])), OUT_W));
    res.z = OUT_W'(clamp_signed(p[2] + longint'($signed(offset_q[2])), OUT_W));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed_plan.push_back(row);
  endtask

  // typed: expectation given by hand rather than by the transform
  task automatic plan_vertex(input coord_t vx, input coord_t vy, input coord_t vz,
                             input bit typed, input longint ex, input longint ey,
                             input longint ez);
    plan_row_t row;
    row        = '{default: '0};
    row.x      = vx;
    row.y      = vy;
    row.z      = vz;
    row.typed  = typed;
    row.want.x = OUT_W'(ex);
    row.want.y = OUT_W'(ey);
    row.want.z = OUT_W'(ez);
    directed_plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One register write; the caller drops the enable after the last of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SCALE:    scale_q     = data[SCALE_W-1:0];
      REG_ROT_X:    rot_q[0]    = data[ROT_REG_W-1:0];
      REG_ROT_Y:    rot_q[1]    = data[ROT_REG_W-1:0];
      REG_ROT_Z:    rot_q[2]    = data[ROT_REG_W-1:0];
      REG_OFFSET_X: offset_q[0] = data[OFFSET_W-1:0];
      REG_OFFSET_Y: offset_q[1] = data[OFFSET_W-1:0];
      REG_OFFSET_Z: offset_q[2] = data[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // Stop offering and let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t vz,
                             input bit typed, input vertex_t want);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i     <= vx;
    in_y_i     <= vy;
    in_z_i     <= vz;
    do @(posedge clk_i); while (!in_ready_o);
    pending_vertices.push_back(typed ? want : transform_vertex(vx, vy, vz));
    vertices_sent++;
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(0, 11))
      0:       return {1'b1, {(COORD_W-1){1'b0}}};
      1:       return {1'b0, {(COORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // New register setting: 0 random, 1 high extremes, 2 low extremes, 3 moderate
  task automatic load_setting(input int mode);
    logic [ROT_REG_W-1:0] corners [4];
    logic [CFG_DATA_W-1:0] scale_word;
    logic [CFG_DATA_W-1:0] offset_word;
    corners[0] = {16'sh7FFF, 16'sh7FFF};
    corners[1] = {16'sh8000, 16'sh8000};
    corners[2] = {16'sh7FFF, 16'sh8000};
    corners[3] = {16'sh8000, 16'sh7FFF};
    wait_idle();
    case (mode)
      1:       scale_word = {16'($urandom()), 16'hFFFF};
      2:       scale_word = {16'($urandom()), 16'($urandom_range(0, 1))};
      3:       scale_word = $urandom_range(64, 1024);
      default: scale_word = $urandom();
    endcase
    write_reg(REG_SCALE, scale_word);
    for (int k = 0; k < 3; k++) begin
      if (mode == 1 || mode == 2) begin
        write_reg(CFG_IDX_W'(REG_ROT_X + k), corners[$urandom_range(0, 3)]);
      end else if (mode == 3 && $urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'(REG_ROT_X + k), ROT_RESET);
      end else begin
        write_reg(CFG_IDX_W'(REG_ROT_X + k), $urandom());
      end
    end
    for (int k = 0; k < 3; k++) begin
      case (mode)
        1:       offset_word = 32'h7FFF_FFFF;
        2:       offset_word = 32'h8000_0000;
        default: offset_word = $urandom();
      endcase
      write_reg(CFG_IDX_W'(REG_OFFSET_X + k), offset_word);
    end
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom());
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int burst;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready_i <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Score each output beat against the oldest expectation
  always @(posedge clk_i) begin : score_results
    vertex_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_vertices.size() == 0) begin
        $error("output beat with nothing expected: x=%0d y=%0d z=%0d",
               out_x_o, out_y_o, out_z_o);
        fail_count++;
      end else begin
        want = pending_vertices.pop_front();
        vertices_scored++;
        if (out_x_o !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x_o);
          fail_count++;
        end
        if (out_y_o !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y_o);
          fail_count++;
        end
        if (out_z_o !== want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, out_z_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t row;
    bit        writing;
    scale_q = SCALE_RESET;
    for (int k = 0; k < 3; k++) begin
      rot_q[k]    = ROT_RESET;
      offset_q[k] = '0;
    end

    // Reset settings: unit scale, no rotation, so out = in * 256
    plan_vertex(0, 0, 0, 1, 0, 0, 0);
    plan_vertex(32767, 32767, 32767, 1, 8388352, 8388352, 8388352);
    plan_vertex(-32768, -32768, -32768, 1, -8388608, -8388608, -8388608);
    plan_vertex(1, -1, 32767, 1, 256, -256, 8388352);
    plan_vertex(-32768, 32767, -1, 1, -8388608, 8388352, -256);
    // write to an index with no register: nothing changes
    plan_write(REG_UNUSED, 32'hDEAD_BEEF);
    plan_vertex(12345, -2222, 3, 1, 3160320, -568832, 768);
    // upper data bits beyond the scale width are dropped: scale 2.0
    plan_write(REG_SCALE, 32'hFFFF_0200);
    plan_vertex(1000, -1000, 32767, 1, 512000, -512000, 16776704);
    plan_write(REG_SCALE, 32'h0000_0000);
    plan_vertex(32767, -32768, 5, 1, 0, 0, 0);
    plan_write(REG_SCALE, 32'h0000_FFFF);
    plan_vertex(-32768, -32768, -32768, 1, -2147450880, -2147450880, -2147450880);
    plan_vertex(32767, 32767, 32767, 1, 2147385345, 2147385345, 2147385345);
    // quarter turn about Z, then extreme trig pairs on X and Y
    plan_write(REG_SCALE, 32'h0000_0100);
    plan_write(REG_ROT_Z, 32'h4000_0000);
    plan_vertex(100, 200, 300, 0, 0, 0, 0);
    plan_write(REG_ROT_X, 32'h7FFF_8000);
    plan_write(REG_ROT_Y, 32'h8000_7FFF);
    plan_vertex(32767, -32768, 32767, 0, 0, 0, 0);
    plan_vertex(-32768, 32767, -32768, 0, 0, 0, 0);
    // offset extremes
    plan_write(REG_OFFSET_X, 32'h7FFF_FFFF);
    plan_write(REG_OFFSET_Y, 32'h8000_0000);
    plan_write(REG_OFFSET_Z, 32'h0000_0080);
    plan_vertex(32767, 32767, -32768, 0, 0, 0, 0);
    plan_vertex(-1, 0, 1, 0, 0, 0, 0);
    // half-way ties: cos 0.5 on X with raw scale, ties go towards +inf
    plan_write(REG_OFFSET_X, 32'h0);
    plan_write(REG_OFFSET_Y, 32'h0);
    plan_write(REG_OFFSET_Z, 32'h0);
    plan_write(REG_SCALE, 32'h0000_0001);
    plan_write(REG_ROT_X, 32'h0000_2000);
    plan_write(REG_ROT_Y, ROT_RESET);
    plan_write(REG_ROT_Z, ROT_RESET);
    plan_vertex(3, 1, -1, 1, 3, 1, 0);
    plan_vertex(-3, -1, 1, 1, -3, 0, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    writing = 1'b0;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_write) begin
        if (!writing) wait_idle();
        write_reg(row.reg_idx, row.reg_data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_vertex(row.x, row.y, row.z, row.typed, row.want);
      end
    end

    // Random phases; the last one runs without idling on either side
    for (int p = 0; p < PHASES; p++) begin
      tx_idle_en = (p != PHASES - 1);
      rx_idle_en = (p != PHASES - 1);
      load_setting(p % 4);
      if (p == 1) hold_off_req = 1'b1;
      repeat (PHASE_VERTICES) begin
        send_vertex(random_coord(), random_coord(), random_coord(), 1'b0, '0);
      end
    end

    wait_idle();
    if (pending_vertices.size() != 0) begin
      $error("%0d expected vertices never came out", pending_vertices.size());
      fail_count++;
    end

    $display("Sent %0d vertices after a %0d-row directed table, scored %0d beats",
             vertices_sent, directed_plan.size(), vertices_scored);
    $display("across %0d random register settings incl. scale, trig and offset extremes",
             settings_loaded);
    if (fail_count == 0) begin
      $display("vertex_scale_rotate_translate_core: match");
    end else begin
      $display("vertex_scale_rotate_translate_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("vertex_scale_rotate_translate_core: mismatch");
    $finish;
  end

endmodule
